>>> rtl/spsl_pkg.sv
// shared constants, codes and channel tables of the servo slew limiter
`default_nettype none

package spsl_pkg;

    localparam int CHAN_W   = 4;
    localparam int ANGLE_W  = 8;
    localparam int DIV_W    = 8;
    localparam int VALUE_W  = 14;
    localparam int TICK_W   = 16;
    localparam int PROD_W   = 16;
    localparam int SUM_W    = 18;
    localparam int DEG_STEP = 39;

    typedef enum logic [0:0] {
        FUNC_SET  = 1'b0,
        FUNC_TICK = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_UPD,
        ST_SRD,
        ST_DIV,
        ST_SWR
    } state_t;

    function automatic int zero_offset(input int idx);
        case (idx)
            0:       return 2944;
            1:       return 3880;
            2:       return 6142;
            3:       return 7312;
            4:       return 6064;
            5:       return 4270;
            6:       return 7000;
            7:       return 6220;
            8:       return 4270;
            9:       return 3100;
            10:      return 4036;
            11:      return 5830;
            default: return 0;
        endcase
    endfunction

    function automatic logic dir_negative(input int idx);
        case (idx) inside
            1, 2, 3, 6, 10, 11: return 1'b1;
            default:            return 1'b0;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> rtl/spsl_if.sv
// command and result channel interfaces of the servo slew limiter
`default_nettype none

interface spsl_cmd_if;
    logic                                 valid;
    logic                                 ready;
    spsl_pkg::func_t                      func;
    logic [spsl_pkg::CHAN_W-1:0]          channel;
    logic signed [spsl_pkg::ANGLE_W-1:0]  angle_deg;
    logic [spsl_pkg::DIV_W-1:0]           divider;

    modport source (output valid, output func, output channel, output angle_deg,
                    output divider, input ready);
    modport sink (input valid, input func, input channel, input angle_deg,
                  input divider, output ready);
endinterface

interface spsl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [spsl_pkg::CHAN_W-1:0]   out_channel;
    logic [spsl_pkg::VALUE_W-1:0]  compare_value;
    logic                          last;

    modport source (output valid, output out_channel, output compare_value,
                    output last, input ready);
    modport sink (input valid, input out_channel, input compare_value,
                  input last, output ready);
endinterface

`default_nettype wire

>>> rtl/spsl_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module spsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/servo_pwm_slew_limiter.sv
// top level of the multi-channel servo pwm slew limiter
//
// cmd channel (valid/ready): a set item (func = set) loads a channel's target
// compare value from its zero offset and the signed angle times 39, saturated,
// and its ticks-per-step divider; a set item to a channel beyond the last is
// dropped. a tick item (func = tick) advances the 16-bit tick count and steps
// each channel whose divider divides the count by one toward its target.
// rsp channel (valid/ready): a tick item yields one item per channel in
// channel order, the last one flagged with last; set items yield nothing.
// per-channel state sits in one ram row {target, current, divider, residue};
// the residue tracks the tick count modulo the divider.
// a tick walks the channels in order, one ram read and one write-back per
// channel. a set item runs a ram read, a 16-step remainder of the tick
// count by the new divider, and the write-back. the first result is
// registered after the ST_RD read and the ST_UPD step that follow the tick.
// at reset every channel reads as its zero offset with divider 2 and the count
// is zero; no clearing pass is needed. a stalled receiver holds the result
// register and the walk waits; the next command is taken once the last result
// of a tick is in the output register.
`default_nettype none

module servo_pwm_slew_limiter #(
    parameter int CHANNELS     = 12,
    parameter int COMPARE_BITS = 14
) (
    input  logic            clk,
    input  logic            rst_n,
    spsl_cmd_if.sink        cmd,
    spsl_rsp_if.source      rsp
);

    localparam int ADDR_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CB      = COMPARE_BITS;
    localparam int DW      = spsl_pkg::DIV_W;
    localparam int TW      = spsl_pkg::TICK_W;
    localparam int BIT_W   = $clog2(TW);
    localparam int CW      = spsl_pkg::CHAN_W;
    localparam int VW      = spsl_pkg::VALUE_W;
    localparam int AW      = spsl_pkg::ANGLE_W;
    localparam int PW      = spsl_pkg::PROD_W;
    localparam int SW      = spsl_pkg::SUM_W;
    localparam int ROW_W   = 2 * CB + 2 * DW;
    localparam int CMP_MAX = (1 << CB) - 1;

    typedef struct packed {
        logic [CB-1:0] target;
        logic [CB-1:0] current;
        logic [DW-1:0] divider;
        logic [DW-1:0] residue;
    } row_t;

    function automatic row_t reset_row(input logic [ADDR_W-1:0] idx);
        int   zo;
        row_t r;
        zo = spsl_pkg::zero_offset(int'(idx));
        if (zo > CMP_MAX)
        begin
            zo = CMP_MAX;
        end
        r.target  = CB'(zo);
        r.current = CB'(zo);
        r.divider = DW'(2);
        r.residue = '0;
        return r;
    endfunction

    spsl_pkg::state_t         state_reg, state_next;
    logic [ADDR_W-1:0]        chan_reg, chan_next;
    logic [TW-1:0]            tick_reg, tick_next;
    logic [CHANNELS-1:0]      valid_reg, valid_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic                     out_valid_reg, out_valid_next;
    logic [CW-1:0]            out_channel_reg, out_channel_next;
    logic [VW-1:0]            out_value_reg, out_value_next;
    logic                     out_last_reg, out_last_next;
    logic signed [AW-1:0]     angle_reg, angle_next;
    logic [DW-1:0]            div_reg, div_next;
    logic signed [PW-1:0]     prod_reg, prod_next;
    logic [DW-1:0]            rem_reg, rem_next;
    logic [ADDR_W-1:0]        rd_addr_reg;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    row_t                     ram_wdata;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [ROW_W-1:0]         ram_rdata;

    row_t                     row_rd;
    row_t                     upd_row;
    logic [DW:0]              res_inc;
    logic [DW-1:0]            res_new;
    logic [CB-1:0]            cur_new;
    logic                     emit;
    logic                     chan_last;
    logic [DW:0]              div_trial;
    logic [DW:0]              div_diff;
    logic [DW-1:0]            rem_step;
    logic signed [PW-1:0]     prod_p;
    logic signed [SW-1:0]     sum;
    logic [CB-1:0]            target_new;
    int                       zo_set;

    spsl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (CHANNELS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // untouched channels read as their reset row
    assign row_rd = valid_reg[rd_addr_reg] ? row_t'(ram_rdata) : reset_row(rd_addr_reg);

    // tick step for the channel in flight
    always_comb
    begin
        res_inc = {1'b0, row_rd.residue} + (DW + 1)'(1);
        if (tick_reg == '0 || res_inc == {1'b0, row_rd.divider})
        begin
            res_new = '0;
        end
        else
        begin
            res_new = res_inc[DW-1:0];
        end
        cur_new = row_rd.current;
        if (res_new == '0)
        begin
            if (row_rd.target > row_rd.current)
            begin
                cur_new = row_rd.current + CB'(1);
            end
            else if (row_rd.target < row_rd.current)
            begin
                cur_new = row_rd.current - CB'(1);
            end
        end
        upd_row         = row_rd;
        upd_row.current = cur_new;
        upd_row.residue = res_new;
    end

    // one remainder bit a cycle
    always_comb
    begin
        div_trial = {rem_reg, tick_reg[bit_reg]};
        div_diff  = div_trial - {1'b0, div_reg};
        if (div_trial >= {1'b0, div_reg})
        begin
            rem_step = div_diff[DW-1:0];
        end
        else
        begin
            rem_step = div_trial[DW-1:0];
        end
    end

    // target from offset and signed angle
    always_comb
    begin
        prod_p = PW'(angle_reg) * PW'(spsl_pkg::DEG_STEP);
        zo_set = spsl_pkg::zero_offset(int'(chan_reg));
        sum    = SW'(zo_set) + SW'(prod_reg);
        if (sum < 0)
        begin
            target_new = '0;
        end
        else if (sum > SW'(CMP_MAX))
        begin
            target_new = CB'(CMP_MAX);
        end
        else
        begin
            target_new = CB'(sum);
        end
    end

    assign emit      = !out_valid_reg || rsp.ready;
    assign chan_last = (chan_reg == ADDR_W'(CHANNELS - 1));

    always_comb
    begin
        state_next       = state_reg;
        chan_next        = chan_reg;
        tick_next        = tick_reg;
        valid_next       = valid_reg;
        bit_next         = bit_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_channel_next = out_channel_reg;
        out_value_next   = out_value_reg;
        out_last_next    = out_last_reg;
        angle_next       = angle_reg;
        div_next         = div_reg;
        prod_next        = prod_reg;
        rem_next         = rem_reg;
        ram_re           = 1'b0;
        ram_raddr        = chan_reg;
        ram_we           = 1'b0;
        ram_waddr        = chan_reg;
        ram_wdata        = upd_row;
        cmd.ready        = 1'b0;

        case (state_reg)
            spsl_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    if (cmd.func == spsl_pkg::FUNC_TICK)
                    begin
                        tick_next  = tick_reg + TW'(1);
                        chan_next  = '0;
                        state_next = spsl_pkg::ST_RD;
                    end
                    else if (int'(cmd.channel) < CHANNELS)
                    begin
                        chan_next  = ADDR_W'(cmd.channel);
                        angle_next = cmd.angle_deg;
                        div_next   = (cmd.divider == '0) ? DW'(1) : cmd.divider;
                        state_next = spsl_pkg::ST_SRD;
                    end
                end
            end
            spsl_pkg::ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = spsl_pkg::ST_UPD;
            end
            spsl_pkg::ST_UPD:
            begin
                if (emit)
                begin
                    ram_we           = 1'b1;
                    ram_wdata        = upd_row;
                    out_valid_next   = 1'b1;
                    out_channel_next = CW'(chan_reg);
                    out_value_next   = VW'(cur_new);
                    out_last_next    = chan_last;
                    if (chan_last)
                    begin
                        state_next = spsl_pkg::ST_IDLE;
                    end
                    else
                    begin
                        chan_next  = chan_reg + ADDR_W'(1);
                        state_next = spsl_pkg::ST_RD;
                    end
                end
            end
            spsl_pkg::ST_SRD:
            begin
                ram_re     = 1'b1;
                prod_next  = spsl_pkg::dir_negative(int'(chan_reg)) ? -prod_p : prod_p;
                rem_next   = '0;
                bit_next   = BIT_W'(TW - 1);
                state_next = spsl_pkg::ST_DIV;
            end
            spsl_pkg::ST_DIV:
            begin
                rem_next = rem_step;
                if (bit_reg == '0)
                begin
                    state_next = spsl_pkg::ST_SWR;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            spsl_pkg::ST_SWR:
            begin
                ram_we            = 1'b1;
                ram_wdata         = row_rd;
                ram_wdata.target  = target_new;
                ram_wdata.divider = div_reg;
                ram_wdata.residue = rem_reg;
                state_next        = spsl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = spsl_pkg::ST_IDLE;
            end
        endcase

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spsl_pkg::ST_IDLE;
            chan_reg      <= '0;
            tick_reg      <= '0;
            valid_reg     <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            tick_reg      <= tick_next;
            valid_reg     <= valid_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_channel_reg <= out_channel_next;
        out_value_reg   <= out_value_next;
        out_last_reg    <= out_last_next;
        angle_reg       <= angle_next;
        div_reg         <= div_next;
        prod_reg        <= prod_next;
        rem_reg         <= rem_next;
        if (ram_re)
        begin
            rd_addr_reg <= ram_raddr;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.out_channel   = out_channel_reg;
    assign rsp.compare_value = out_value_reg;
    assign rsp.last          = out_last_reg;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spsl_pkg::ST_UPD |-> row_rd.divider != '0)
        else $error("stored divider is zero");

    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spsl_pkg::ST_UPD |-> row_rd.residue < row_rd.divider)
        else $error("residue not below divider");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spsl_pkg::ST_UPD && emit && chan_last)
        |=> (state_reg == spsl_pkg::ST_IDLE && rsp.valid && rsp.last))
        else $error("tick walk did not end with a last item");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == spsl_pkg::ST_DIV && bit_reg == '0)
        |=> state_reg == spsl_pkg::ST_SWR)
        else $error("remainder did not finish in time");
`endif

endmodule

`default_nettype wire

>>> sim/testbench.sv
// self-checking testbench of the twelve-channel servo pwm slew limiter
`timescale 1ns / 100ps

module testbench;

    localparam int NUM_CH      = 12;
    localparam int CMP_MAX     = (1 << spsl_pkg::VALUE_W) - 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [spsl_pkg::CHAN_W-1:0]  channel;
        logic [spsl_pkg::VALUE_W-1:0] value;
        logic                         last;
    } servo_report_t;

    class servo_ramp_scoreboard;
        int            home_cmp [NUM_CH];
        bit            reversed [NUM_CH];
        int            target   [NUM_CH];
        int            current  [NUM_CH];
        int            rate_div [NUM_CH];
        bit [15:0]     tick_count;
        servo_report_t pending[$];
        int            failures;

        function new();
            home_cmp = '{2944, 3880, 6142, 7312, 6064, 4270,
                         7000, 6220, 4270, 3100, 4036, 5830};
            reversed = '{0, 1, 1, 1, 0, 0, 1, 0, 0, 0, 1, 1};
            for (int c = 0; c < NUM_CH; c++)
            begin
                target[c]   = home_cmp[c];
                current[c]  = home_cmp[c];
                rate_div[c] = 2;
            end
            tick_count = '0;
            failures   = 0;
        endfunction

        function void note_command(input spsl_pkg::func_t f,
                                   input logic [spsl_pkg::CHAN_W-1:0] ch,
                                   input logic signed [spsl_pkg::ANGLE_W-1:0] ang,
                                   input logic [spsl_pkg::DIV_W-1:0] dv);
            int            raw;
            servo_report_t r;
            if (f == spsl_pkg::FUNC_SET)
            begin
                if (ch < NUM_CH)
                begin
                    raw = reversed[ch] ? home_cmp[ch] - int'(ang) * spsl_pkg::DEG_STEP
                                       : home_cmp[ch] + int'(ang) * spsl_pkg::DEG_STEP;
                    target[ch]   = (raw < 0) ? 0 : ((raw > CMP_MAX) ? CMP_MAX : raw);
                    rate_div[ch] = (dv == 0) ? 1 : int'(dv);
                end
            end
            else
            begin
                tick_count = tick_count + 16'd1;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    if (int'(tick_count) % rate_div[c] == 0)
                    begin
                        if (target[c] > current[c])
                            current[c]++;
                        else if (target[c] < current[c])
                            current[c]--;
                    end
                    r.channel = spsl_pkg::CHAN_W'(c);
                    r.value   = spsl_pkg::VALUE_W'(current[c]);
                    r.last    = (c == NUM_CH - 1);
                    pending.push_back(r);
                end
            end
        endfunction

        function void check_report(input logic [spsl_pkg::CHAN_W-1:0] ch,
                                   input logic [spsl_pkg::VALUE_W-1:0] val,
                                   input logic last);
            servo_report_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected item: out_channel %0d compare_value %0d last %0b",
                       ch, val, last);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (ch !== want.channel)
            begin
                $error("out_channel: expected %0d, actual %0d", want.channel, ch);
                failures++;
            end
            if (val !== want.value)
            begin
                $error("compare_value: expected %0d, actual %0d", want.value, val);
                failures++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, last);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   quiet_cycles;

    servo_ramp_scoreboard ramp_sb = new();

    spsl_cmd_if cmd_if ();
    spsl_rsp_if rsp_if ();

    servo_pwm_slew_limiter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic send_command(input spsl_pkg::func_t f,
                                input logic [spsl_pkg::CHAN_W-1:0] ch,
                                input logic signed [spsl_pkg::ANGLE_W-1:0] ang,
                                input logic [spsl_pkg::DIV_W-1:0] dv);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.func      <= f;
        cmd_if.channel   <= ch;
        cmd_if.angle_deg <= ang;
        cmd_if.divider   <= dv;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        ramp_sb.note_command(f, ch, ang, dv);
    endtask

    task automatic send_set(input logic [spsl_pkg::CHAN_W-1:0] ch,
                            input logic signed [spsl_pkg::ANGLE_W-1:0] ang,
                            input logic [spsl_pkg::DIV_W-1:0] dv);
        send_command(spsl_pkg::FUNC_SET, ch, ang, dv);
    endtask

    task automatic send_tick();
        send_command(spsl_pkg::FUNC_TICK, spsl_pkg::CHAN_W'($urandom()),
                     spsl_pkg::ANGLE_W'($urandom()), spsl_pkg::DIV_W'($urandom()));
    endtask

    task automatic run_random(input int count);
        int                                  pick;
        logic [spsl_pkg::CHAN_W-1:0]         ch;
        logic signed [spsl_pkg::ANGLE_W-1:0] ang;
        logic [spsl_pkg::DIV_W-1:0]          dv;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 55)
            begin
                send_tick();
            end
            else
            begin
                ch = ($urandom_range(99) < 85)
                   ? spsl_pkg::CHAN_W'($urandom_range(NUM_CH - 1))
                   : spsl_pkg::CHAN_W'($urandom_range(15, NUM_CH));
                ang = ($urandom_range(99) < 60)
                    ? spsl_pkg::ANGLE_W'(int'($urandom_range(6)) - 3)
                    : spsl_pkg::ANGLE_W'($urandom());
                pick = $urandom_range(99);
                dv = (pick < 50) ? spsl_pkg::DIV_W'($urandom_range(3, 1))
                   : (pick < 65) ? spsl_pkg::DIV_W'(0) : spsl_pkg::DIV_W'($urandom());
                send_set(ch, ang, dv);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
                ramp_sb.check_report(rsp_if.out_channel, rsp_if.compare_value, rsp_if.last);
            rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.func       <= spsl_pkg::FUNC_SET;
        cmd_if.channel    <= '0;
        cmd_if.angle_deg  <= '0;
        cmd_if.divider    <= '0;
        sender_idle_pct   = 30;
        receiver_idle_pct = 74;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, low saturation, zero divider, dropped channels
        send_tick();
        send_set(4'd0, -8'sd128, 8'd0);
        send_set(4'd1, 8'sd127, 8'd255);
        send_set(4'd3, 8'sd127, 8'd1);
        send_set(4'd4, 8'sd127, 8'd1);
        send_set(4'd2, 8'sd1, 8'd2);
        send_set(4'd12, 8'sd5, 8'd1);
        send_set(4'd15, -8'sd128, 8'd0);
        send_set(4'd11, -8'sd1, 8'd3);
        send_set(4'd7, 8'sd0, 8'd1);
        send_set(4'd5, -8'sd128, 8'd255);
        repeat (12) send_tick();

        run_random(49);
        sender_idle_pct   = 74;
        receiver_idle_pct = 30;
        run_random(49);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random(49);
        cmd_if.valid <= 1'b0;

        while (ramp_sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (ramp_sb.failures == 0 && ramp_sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
